[hw/rtl/single_wire_humidity_sensor_reader_assert.svh]
// Assertion macros for the single-wire humidity sensor reader checkers.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define SWHS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swhs check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define SWHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swhs check failed");

`endif

[hw/rtl/swhs_pkg.sv]
`timescale 1ns / 1ps

package swhs_pkg;

   localparam int unsigned FRAME_BITS = 40;

   // register indexes on the csr port
   localparam logic [2:0] CSR_SENSOR_TYPE  = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT      = 3'd1;
   localparam logic [2:0] CSR_WAKE_HIGH    = 3'd2;
   localparam logic [2:0] CSR_START_LOW    = 3'd3;
   localparam logic [2:0] CSR_RELEASE_HIGH = 3'd4;
   localparam logic [2:0] CSR_SETTLE       = 3'd5;
   localparam logic [2:0] CSR_MIN_INTERVAL = 3'd6;

   // status codes
   localparam logic [1:0] STAT_FRESH    = 2'd0;
   localparam logic [1:0] STAT_CACHED   = 2'd1;
   localparam logic [1:0] STAT_TIMEOUT  = 2'd2;
   localparam logic [1:0] STAT_CHECKSUM = 2'd3;

   localparam logic [21:0] SINCE_MAX = 22'h3FFFFF;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int unsigned DIV10_SHIFT = 19;

   typedef struct packed {
      logic        sensor_type;
      logic [15:0] timeout_ticks;
      logic [19:0] wake_high_ticks;
      logic [19:0] start_low_ticks;
      logic [9:0]  release_high_ticks;
      logic [9:0]  settle_ticks;
      logic [21:0] min_interval_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sensor_type:        1'b1,
      timeout_ticks:      16'd1000,
      wake_high_ticks:    20'd50000,
      start_low_ticks:    20'd20000,
      release_high_ticks: 10'd40,
      settle_ticks:       10'd10,
      min_interval_ticks: 22'd2000000
   };

   typedef struct packed {
      logic               sum_ok;
      logic [12:0]        humidity;
      logic signed [12:0] temperature;
   } decode_type;

   // one result item; bit order matches rsp_tdata
   typedef struct packed {
      logic signed [12:0] temperature;
      logic [12:0]        humidity;
      logic [1:0]         status_code;
      logic               read_ok;
      logic               done_res;
      logic               drive_value;
      logic               drive_enable;
   } step_type;

endpackage

[hw/rtl/swhs_frame_decode.sv]
`timescale 1ns / 1ps

// Checksum and unit conversion of a finished 40-bit frame.
module swhs_frame_decode (
   input  logic [swhs_pkg::FRAME_BITS-1:0] frame,
   input  logic                            sensor_type,
   output swhs_pkg::decode_type            result
);

   logic [7:0]  b0, b1, b2, b3, b4;
   logic [7:0]  sum;
   logic [15:0] hum_raw, temp_raw;
   logic [31:0] hum_prod, temp_prod;
   logic [12:0] hum_q, temp_q;

   assign b0 = frame[39:32];
   assign b1 = frame[31:24];
   assign b2 = frame[23:16];
   assign b3 = frame[15:8];
   assign b4 = frame[7:0];

   assign sum = b0 + b1 + b2 + b3;

   assign hum_raw  = {b0, b1};
   assign temp_raw = {1'b0, b2[6:0], b3};

   // divide by ten through the reciprocal
   assign hum_prod  = hum_raw * swhs_pkg::DIV10_RECIP;
   assign temp_prod = temp_raw * swhs_pkg::DIV10_RECIP;
   assign hum_q     = hum_prod[swhs_pkg::DIV10_SHIFT +: 13];
   assign temp_q    = temp_prod[swhs_pkg::DIV10_SHIFT +: 13];

   always_comb begin
      result.sum_ok = (sum == b4);
      if (!sensor_type) begin
         result.humidity    = {5'd0, b0};
         result.temperature = $signed({5'd0, b2});
      end else begin
         result.humidity    = hum_q;
         // sign-magnitude to two's complement
         result.temperature = b2[7] ? $signed(13'd0 - temp_q) : $signed(temp_q);
      end
   end

endmodule

[hw/rtl/swhs_core.sv]
`timescale 1ns / 1ps

// Transaction sequencer: handles one line sample per step.
module swhs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                read_request,
   input  logic                line_level,
   input  swhs_pkg::cfg_type   cfg,
   output swhs_pkg::step_type  step
);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_WAKE   = 4'd1,
      PH_START  = 4'd2,
      PH_REL    = 4'd3,
      PH_SETTLE = 4'd4,
      PH_RLOW   = 4'd5,
      PH_RHIGH  = 4'd6,
      PH_BLOW   = 4'd7,
      PH_BHIGH  = 4'd8
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [19:0]                     ticks_ff, ticks_in;
   logic [15:0]                     low_ff, low_in;
   logic [5:0]                      bit_ff, bit_in;
   logic [swhs_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic [12:0]                     hum_ff, hum_in;
   logic signed [12:0]              temp_ff, temp_in;
   logic                            ok_ff, ok_in;
   logic                            first_ff, first_in;
   logic [21:0]                     since_ff, since_in;

   swhs_pkg::decode_type            dec;

   logic                            timed_act, restarted, fail, finish, go_on, level;
   phase_type                       tph, rph;
   logic [20:0]                     t1;

   function automatic logic [19:0] timed_len(phase_type p, swhs_pkg::cfg_type c);
      logic [19:0] r;
      unique case (p)
         PH_WAKE:  r = c.wake_high_ticks;
         PH_START: r = c.start_low_ticks;
         PH_REL:   r = {10'd0, c.release_high_ticks};
         default:  r = {10'd0, c.settle_ticks};
      endcase
      return r;
   endfunction

   function automatic phase_type succ(phase_type p);
      phase_type r;
      unique case (p)
         PH_WAKE:  r = PH_START;
         PH_START: r = PH_REL;
         PH_REL:   r = PH_SETTLE;
         default:  r = PH_RLOW;
      endcase
      return r;
   endfunction

   // skip timed phases configured to zero length
   function automatic phase_type skip_zero(phase_type p, swhs_pkg::cfg_type c);
      phase_type r;
      r = p;
      if (r == PH_WAKE && c.wake_high_ticks == '0) r = PH_START;
      if (r == PH_START && c.start_low_ticks == '0) r = PH_REL;
      if (r == PH_REL && c.release_high_ticks == '0) r = PH_SETTLE;
      if (r == PH_SETTLE && c.settle_ticks == '0) r = PH_RLOW;
      return r;
   endfunction

   swhs_frame_decode u_decode (
      .frame       (frame_in),
      .sensor_type (cfg.sensor_type),
      .result      (dec)
   );

   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      low_in    = low_ff;
      bit_in    = bit_ff;
      frame_in  = frame_ff;
      hum_in    = hum_ff;
      temp_in   = temp_ff;
      ok_in     = ok_ff;
      first_in  = first_ff;
      since_in  = since_ff;
      step      = '0;
      timed_act = 1'b0;
      restarted = 1'b0;
      fail      = 1'b0;
      finish    = 1'b0;
      go_on     = 1'b0;
      tph       = phase_ff;
      rph       = PH_RLOW;
      t1        = '0;
      level     = !(phase_ff == PH_RLOW || phase_ff == PH_BLOW);

      unique case (phase_ff) inside
         PH_WAKE, PH_START, PH_REL, PH_SETTLE: begin
            timed_act = 1'b1;
         end
         PH_RLOW, PH_RHIGH, PH_BLOW, PH_BHIGH: begin
            if (line_level == level) begin
               if (ticks_ff >= {4'd0, cfg.timeout_ticks}) begin
                  fail = 1'b1;
               end else begin
                  ticks_in = ticks_ff + 20'd1;
               end
            end else if (ticks_ff == '0) begin
               fail = 1'b1;
            end else begin
               go_on = 1'b1;
               unique case (phase_ff)
                  PH_RLOW:  phase_in = PH_RHIGH;
                  PH_RHIGH: phase_in = PH_BLOW;
                  PH_BLOW: begin
                     low_in   = ticks_ff[15:0];
                     phase_in = PH_BHIGH;
                  end
                  default: begin
                     frame_in = {frame_ff[swhs_pkg::FRAME_BITS-2:0],
                                 (ticks_ff > {4'd0, low_ff})};
                     bit_in   = bit_ff + 6'd1;
                     if (bit_in >= 6'(swhs_pkg::FRAME_BITS)) begin
                        go_on  = 1'b0;
                        finish = 1'b1;
                     end else begin
                        phase_in = PH_BLOW;
                     end
                  end
               endcase
               if (go_on) begin
                  if (cfg.timeout_ticks == '0) begin
                     fail = 1'b1;
                  end else begin
                     ticks_in = 20'd1;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (read_request) begin
               if (!first_ff && since_ff < cfg.min_interval_ticks) begin
                  step.done_res    = 1'b1;
                  step.status_code = swhs_pkg::STAT_CACHED;
               end else begin
                  first_in  = 1'b0;
                  since_in  = '0;
                  restarted = 1'b1;
                  frame_in  = '0;
                  bit_in    = '0;
                  low_in    = '0;
                  rph       = skip_zero(PH_WAKE, cfg);
                  if (rph == PH_RLOW) begin
                     phase_in = PH_RLOW;
                     ticks_in = '0;
                  end else begin
                     timed_act = 1'b1;
                     tph       = rph;
                  end
               end
            end
         end
      endcase

      // one tick of a wake, start, release or settle phase
      if (timed_act) begin
         step.drive_enable = (tph != PH_SETTLE);
         step.drive_value  = (tph == PH_WAKE || tph == PH_REL);
         t1 = restarted ? 21'd1 : ({1'b0, ticks_ff} + 21'd1);
         if (t1 >= {1'b0, timed_len(tph, cfg)}) begin
            phase_in = skip_zero(succ(tph), cfg);
            ticks_in = '0;
         end else begin
            phase_in = tph;
            ticks_in = t1[19:0];
         end
      end

      if (fail) begin
         step.done_res    = 1'b1;
         step.status_code = swhs_pkg::STAT_TIMEOUT;
      end
      if (finish) begin
         step.done_res    = 1'b1;
         step.status_code = dec.sum_ok ? swhs_pkg::STAT_FRESH : swhs_pkg::STAT_CHECKSUM;
      end
      if (fail || (finish && !dec.sum_ok)) begin
         ok_in   = 1'b0;
         hum_in  = '0;
         temp_in = '0;
      end else if (finish) begin
         ok_in   = 1'b1;
         hum_in  = dec.humidity;
         temp_in = dec.temperature;
      end
      if (fail || finish) begin
         phase_in = PH_IDLE;
         ticks_in = '0;
      end

      if (!restarted && since_ff != swhs_pkg::SINCE_MAX) begin
         since_in = since_ff + 22'd1;
      end

      step.read_ok     = ok_in;
      step.humidity    = hum_in;
      step.temperature = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         low_ff   <= '0;
         bit_ff   <= '0;
         frame_ff <= '0;
         hum_ff   <= '0;
         temp_ff  <= '0;
         ok_ff    <= 1'b0;
         first_ff <= 1'b1;
         since_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         low_ff   <= low_in;
         bit_ff   <= bit_in;
         frame_ff <= frame_in;
         hum_ff   <= hum_in;
         temp_ff  <= temp_in;
         ok_ff    <= ok_in;
         first_ff <= first_in;
         since_ff <= since_in;
      end
   end

endmodule

[hw/rtl/single_wire_humidity_sensor_reader.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// req_      in   tvalid/tready      tdata[7:0]: read_request, line_level
// rsp_      out  tvalid/tready      tdata[31:0]: one result item per req item
// csr_      in   we (no handshake)  index[2:0], wdata[21:0]
//
// Every req item is one line sample and yields exactly one rsp item.
// Items pass the input register, then the step logic into the output register.
// Throughput is one item per cycle; the pacing loop is the sequencer state
// update (counters, frame shifter, checksum and divide-by-ten multiply).
// Reset is synchronous and active high; config returns to its reset values.
// A stalled rsp holds its item; req then waits once the input register is full.
module single_wire_humidity_sensor_reader (
   input  logic        clock,
   input  logic        reset,
   // req item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] read_request, [1] line_level, [7:2] zero
   // rsp item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] drive_enable, [1] drive_value, [2] done_res,
                                    // [3] read_ok, [5:4] status_code,
                                    // [18:6] humidity, [31:19] temperature
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);

   swhs_pkg::cfg_type  cfg_ff;
   swhs_pkg::step_type step, rsp_ff;

   logic in_valid_ff, in_req_ff, in_line_ff;
   logic rsp_valid_ff;
   logic out_free, step_en, req_fire;

   // output slot free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= swhs_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            swhs_pkg::CSR_SENSOR_TYPE:  cfg_ff.sensor_type        <= csr_wdata[0];
            swhs_pkg::CSR_TIMEOUT:      cfg_ff.timeout_ticks      <= csr_wdata[15:0];
            swhs_pkg::CSR_WAKE_HIGH:    cfg_ff.wake_high_ticks    <= csr_wdata[19:0];
            swhs_pkg::CSR_START_LOW:    cfg_ff.start_low_ticks    <= csr_wdata[19:0];
            swhs_pkg::CSR_RELEASE_HIGH: cfg_ff.release_high_ticks <= csr_wdata[9:0];
            swhs_pkg::CSR_SETTLE:       cfg_ff.settle_ticks       <= csr_wdata[9:0];
            swhs_pkg::CSR_MIN_INTERVAL: cfg_ff.min_interval_ticks <= csr_wdata[21:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (step_en) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff  <= req_tdata[0];
         in_line_ff <= req_tdata[1];
      end
   end

   swhs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .read_request (in_req_ff),
      .line_level   (in_line_ff),
      .cfg          (cfg_ff),
      .step         (step)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

[hw/rtl/swhs_checker.sv]
`timescale 1ns / 1ps
`include "single_wire_humidity_sensor_reader_assert.svh"

// Port-level checks on the result stream.
module swhs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic       de, dv, done, ok;
   logic [1:0] st;
   logic       stalled, quiet, failed, fresh;

   assign de   = rsp_tdata[0];
   assign dv   = rsp_tdata[1];
   assign done = rsp_tdata[2];
   assign ok   = rsp_tdata[3];
   assign st   = rsp_tdata[5:4];

   assign stalled = rsp_tvalid && !rsp_tready;
   assign quiet   = rsp_tvalid && !done;
   assign failed  = rsp_tvalid && done &&
                    (st == swhs_pkg::STAT_TIMEOUT || st == swhs_pkg::STAT_CHECKSUM);
   assign fresh   = rsp_tvalid && done && (st == swhs_pkg::STAT_FRESH);

   // stalled item holds
   `SWHS_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata))
   // line is only driven high while driven at all
   `SWHS_ASSERT_SAME(a_drive_value, clock, reset, rsp_tvalid && dv, de)
   // non-done items carry a zero status
   `SWHS_ASSERT_SAME(a_status_idle, clock, reset, quiet, st == swhs_pkg::STAT_FRESH)
   // a failed read clears the cached result
   `SWHS_ASSERT_SAME(a_fail_clears, clock, reset, failed, !ok && rsp_tdata[31:6] == '0)
   // a fresh good read is valid
   `SWHS_ASSERT_SAME(a_fresh_ok, clock, reset, fresh, ok)

endmodule

bind single_wire_humidity_sensor_reader swhs_checker u_swhs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[test/tb_single_wire_humidity_sensor_reader.sv]
`timescale 1ns / 1ps

// Checks the single-wire sensor reader one line sample per item. A mirror of the
// reader's sequencer predicts the rsp item for every accepted req item, and the
// driver reads the mirror's phase to shape well-formed sensor frames.
module tb_single_wire_humidity_sensor_reader;

   // sequencer phases, in the order the reader walks them
   typedef enum logic [3:0] {
      P_IDLE, P_WAKE, P_START, P_RELEASE, P_SETTLE,
      P_RESP_LOW, P_RESP_HIGH, P_BIT_LOW, P_BIT_HIGH
   } phase_type;

   // ways a sensor reply can go wrong
   typedef enum {FLT_NONE, FLT_NO_RESPONSE, FLT_LONG_PULSE, FLT_NOISE} fault_type;

   // Mirror of the reader: register copy, sequencer state, cached reading and
   // the rsp items still owed by the block.
   class reader_mirror;
      swhs_pkg::cfg_type  regs;
      phase_type          phase;
      int unsigned        ticks;
      logic [15:0]        low_len;
      logic [5:0]         bit_count;
      logic [39:0]        frame;
      logic [12:0]        hum_keep;
      logic [12:0]        temp_keep;
      logic               ok_keep;
      logic               first_pending;
      logic [21:0]        since;
      swhs_pkg::step_type due_steps[$];
      int                 errors;

      function new();
         regs = swhs_pkg::CFG_RESET;
         phase = P_IDLE;
         ticks = 0;
         low_len = '0;
         bit_count = '0;
         frame = '0;
         hum_keep = '0;
         temp_keep = '0;
         ok_keep = 1'b0;
         first_pending = 1'b1;
         since = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [21:0] value);
         case (index)
            swhs_pkg::CSR_SENSOR_TYPE:  regs.sensor_type = value[0];
            swhs_pkg::CSR_TIMEOUT:      regs.timeout_ticks = value[15:0];
            swhs_pkg::CSR_WAKE_HIGH:    regs.wake_high_ticks = value[19:0];
            swhs_pkg::CSR_START_LOW:    regs.start_low_ticks = value[19:0];
            swhs_pkg::CSR_RELEASE_HIGH: regs.release_high_ticks = value[9:0];
            swhs_pkg::CSR_SETTLE:       regs.settle_ticks = value[9:0];
            swhs_pkg::CSR_MIN_INTERVAL: regs.min_interval_ticks = value;
            default: ;
         endcase
      endfunction

      function int unsigned span(phase_type p);
         case (p)
            P_WAKE:    return regs.wake_high_ticks;
            P_START:   return regs.start_low_ticks;
            P_RELEASE: return regs.release_high_ticks;
            default:   return regs.settle_ticks;
         endcase
      endfunction

      // zero-length timed phases are passed over
      function void enter(phase_type p);
         while (p >= P_WAKE && p <= P_SETTLE && span(p) == 0)
            p = phase_type'(p + 1);
         phase = p;
         ticks = 0;
      endfunction

      function void drive_timed(inout swhs_pkg::step_type s);
         s.drive_enable = (phase != P_SETTLE);
         s.drive_value = (phase == P_WAKE || phase == P_RELEASE);
         ticks++;
         if (ticks >= span(phase))
            enter(phase_type'(phase + 1));
      endfunction

      function void drop_reading();
         ok_keep = 1'b0;
         hum_keep = '0;
         temp_keep = '0;
         phase = P_IDLE;
         ticks = 0;
      endfunction

      function logic [1:0] close_frame();
         logic [7:0]  b0, b1, b2, b3, b4, sum;
         int unsigned t, h;
         b0 = frame[39:32];
         b1 = frame[31:24];
         b2 = frame[23:16];
         b3 = frame[15:8];
         b4 = frame[7:0];
         sum = b0 + b1 + b2 + b3;
         if (sum != b4) begin
            drop_reading();
            return swhs_pkg::STAT_CHECKSUM;
         end
         if (!regs.sensor_type) begin
            hum_keep = 13'(b0);
            temp_keep = 13'(b2);
         end else begin
            // sign-magnitude tenths, truncated toward zero
            h = {b0, b1};
            t = {b2[6:0], b3};
            hum_keep = 13'(h / 10);
            t = t / 10;
            temp_keep = b2[7] ? 13'(0 - t) : 13'(t);
         end
         ok_keep = 1'b1;
         phase = P_IDLE;
         ticks = 0;
         return swhs_pkg::STAT_FRESH;
      endfunction

      // one sample of a timed pulse; returns 1 when the read ends
      function bit time_pulse(logic line, output logic [1:0] stat);
         logic        level;
         int unsigned len;
         stat = swhs_pkg::STAT_FRESH;
         level = (phase == P_RESP_HIGH || phase == P_BIT_HIGH);
         if (line == level) begin
            if (ticks >= regs.timeout_ticks) begin
               drop_reading();
               stat = swhs_pkg::STAT_TIMEOUT;
               return 1'b1;
            end
            ticks++;
            return 1'b0;
         end
         // pulse missing at its first sample
         if (ticks == 0) begin
            drop_reading();
            stat = swhs_pkg::STAT_TIMEOUT;
            return 1'b1;
         end
         len = ticks;
         case (phase)
            P_RESP_LOW:  phase = P_RESP_HIGH;
            P_RESP_HIGH: phase = P_BIT_LOW;
            P_BIT_LOW: begin
               low_len = len[15:0];
               phase = P_BIT_HIGH;
            end
            default: begin
               frame = {frame[38:0], len > low_len};
               bit_count++;
               if (bit_count >= swhs_pkg::FRAME_BITS) begin
                  stat = close_frame();
                  return 1'b1;
               end
               phase = P_BIT_LOW;
            end
         endcase
         if (regs.timeout_ticks == 0) begin
            drop_reading();
            stat = swhs_pkg::STAT_TIMEOUT;
            return 1'b1;
         end
         // the ending sample is the first one of the next pulse
         ticks = 1;
         return 1'b0;
      endfunction

      function void take_sample(logic req, logic line);
         swhs_pkg::step_type s;
         bit                 restarted;
         bit                 fin;
         logic [1:0]         stat;
         s = '0;
         restarted = 1'b0;
         if (phase == P_IDLE) begin
            if (req) begin
               if (!first_pending && since < regs.min_interval_ticks) begin
                  s.done_res = 1'b1;
                  s.status_code = swhs_pkg::STAT_CACHED;
               end else begin
                  first_pending = 1'b0;
                  since = '0;
                  restarted = 1'b1;
                  frame = '0;
                  bit_count = '0;
                  low_len = '0;
                  enter(P_WAKE);
                  if (phase <= P_SETTLE)
                     drive_timed(s);
               end
            end
         end else if (phase <= P_SETTLE) begin
            drive_timed(s);
         end else begin
            fin = time_pulse(line, stat);
            if (fin) begin
               s.done_res = 1'b1;
               s.status_code = stat;
            end
         end
         if (!restarted && since < swhs_pkg::SINCE_MAX)
            since++;
         s.read_ok = ok_keep;
         s.humidity = hum_keep;
         s.temperature = temp_keep;
         due_steps.push_back(s);
      endfunction

      function void match_field(string name, logic signed [13:0] want,
                                logic signed [13:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_step(logic [31:0] data);
         swhs_pkg::step_type got, want;
         got = data;
         if (due_steps.size() == 0) begin
            $display("%0t: rsp item %h with nothing owed", $time, data);
            errors++;
            return;
         end
         want = due_steps.pop_front();
         match_field("drive_enable", want.drive_enable, got.drive_enable);
         match_field("drive_value", want.drive_value, got.drive_value);
         match_field("done_res", want.done_res, got.done_res);
         match_field("read_ok", want.read_ok, got.read_ok);
         match_field("status_code", want.status_code, got.status_code);
         match_field("humidity", want.humidity, got.humidity);
         match_field("temperature", want.temperature, got.temperature);
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = swhs_pkg::CSR_SENSOR_TYPE;
   logic [21:0] csr_wdata = '0;

   reader_mirror mirror = new();
   int unsigned  sent = 0;
   int unsigned  cycles = 0;
   bit           steady = 1'b0;   // no idling on either side while set

   single_wire_humidity_sensor_reader dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver: stalls about 6 percent of the time while not steady
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 6);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_step(rsp_tdata);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one line sample; the mirror advances when the item is taken
   task automatic send_sample(input logic req, input logic line);
      if (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, line, req};
      do @(posedge clock); while (!req_tready);
      mirror.take_sample(req, line);
      sent++;
   endtask

   // hold the sender until every owed rsp item is back
   task automatic flush_out();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.due_steps.size() != 0);
   endtask

   task automatic load_regs(input swhs_pkg::cfg_type c);
      logic [2:0]  reg_index [7] = '{swhs_pkg::CSR_SENSOR_TYPE, swhs_pkg::CSR_TIMEOUT,
                                     swhs_pkg::CSR_WAKE_HIGH, swhs_pkg::CSR_START_LOW,
                                     swhs_pkg::CSR_RELEASE_HIGH, swhs_pkg::CSR_SETTLE,
                                     swhs_pkg::CSR_MIN_INTERVAL};
      logic [21:0] vals [7];
      vals = '{22'(c.sensor_type), 22'(c.timeout_ticks), 22'(c.wake_high_ticks),
               22'(c.start_low_ticks), 22'(c.release_high_ticks), 22'(c.settle_ticks),
               c.min_interval_ticks};
      for (int i = 0; i < $size(reg_index); i++) begin
         csr_we <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         mirror.write_reg(reg_index[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [39:0] make_frame(logic [7:0] b0, logic [7:0] b1,
                                              logic [7:0] b2, logic [7:0] b3, bit good);
      logic [7:0] sum;
      sum = b0 + b1 + b2 + b3;
      if (!good)
         sum = sum + 8'($urandom_range(255, 1));
      return {b0, b1, b2, b3, sum};
   endfunction

   // One read: request, then line samples until the reader is idle again.
   // Requests sprinkled over the busy part must be ignored.
   task automatic read_cycle(input logic [39:0] bits, input fault_type fault);
      int unsigned limit, lo, hi;
      int unsigned lens [82];
      send_sample(1'b1, 1'($urandom_range(1)));
      if (mirror.phase == P_IDLE)
         return;   // served from cache
      // wake/start/release/settle: line level does not matter
      while (mirror.phase != P_IDLE && mirror.phase <= P_SETTLE)
         send_sample($urandom_range(9) == 0, 1'($urandom_range(1)));
      if (fault == FLT_NO_RESPONSE) begin
         send_sample($urandom_range(9) == 0, 1'b1);
         return;
      end
      if (fault == FLT_NOISE) begin
         while (mirror.phase != P_IDLE)
            send_sample($urandom_range(9) == 0, 1'($urandom_range(1)));
         return;
      end
      limit = (mirror.regs.timeout_ticks < 5) ? mirror.regs.timeout_ticks : 5;
      if (limit == 0)
         limit = 1;
      lens[0] = $urandom_range(limit, 1);
      lens[1] = $urandom_range(limit, 1);
      // bit is one when its high pulse outlasts its low pulse
      for (int b = 0; b < 40; b++) begin
         if (bits[39 - b] && limit > 1) begin
            lo = $urandom_range(limit - 1, 1);
            hi = $urandom_range(limit, lo + 1);
         end else begin
            lo = $urandom_range(limit, 1);
            hi = $urandom_range(lo, 1);
         end
         lens[2 + 2 * b] = lo;
         lens[3 + 2 * b] = hi;
      end
      if (fault == FLT_LONG_PULSE)
         lens[$urandom_range(81)] = mirror.regs.timeout_ticks + 1;
      for (int k = 0; k < 82; k++) begin
         for (int n = 0; n < lens[k]; n++) begin
            send_sample($urandom_range(9) == 0, 1'(k % 2));
            if (mirror.phase == P_IDLE)
               return;
         end
      end
      // falling edge that closes the last bit
      while (mirror.phase != P_IDLE)
         send_sample($urandom_range(9) == 0, 1'b0);
   endtask

   initial begin
      swhs_pkg::cfg_type c;
      int unsigned       base;
      int unsigned       roll;
      fault_type         f;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle samples under reset settings
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      flush_out();

      // all timed phases zero: request jumps straight to the response wait;
      // timeout zero fails the first sample
      c = '{sensor_type: 1'b1, timeout_ticks: 16'd0, wake_high_ticks: 20'd0,
            start_low_ticks: 20'd0, release_high_ticks: 10'd0, settle_ticks: 10'd0,
            min_interval_ticks: 22'd0};
      load_regs(c);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      flush_out();

      // tenths format: extremes, checksum error, missing and overlong pulses
      c = '{sensor_type: 1'b1, timeout_ticks: 16'd3, wake_high_ticks: 20'd1,
            start_low_ticks: 20'd2, release_high_ticks: 10'd1, settle_ticks: 10'd1,
            min_interval_ticks: 22'd0};
      load_regs(c);
      read_cycle(make_frame(8'hFF, 8'hFF, 8'h7F, 8'hFF, 1'b1), FLT_NONE);
      read_cycle(make_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1), FLT_NONE);
      read_cycle(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), FLT_NONE);
      read_cycle(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b1), FLT_NONE);
      read_cycle(make_frame(8'h12, 8'h34, 8'h81, 8'h05, 1'b0), FLT_NONE);
      read_cycle(make_frame(8'h02, 8'h58, 8'h00, 8'hE1, 1'b1), FLT_NO_RESPONSE);
      read_cycle(make_frame(8'h02, 8'h58, 8'h00, 8'hE1, 1'b1), FLT_LONG_PULSE);
      flush_out();

      // byte format, then requests inside the hold-off come from cache
      c.sensor_type = 1'b0;
      c.min_interval_ticks = 22'd400;
      load_regs(c);
      read_cycle(make_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1), FLT_NONE);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      flush_out();

      // top of every register; long hold-off keeps all requests cached
      c = '{sensor_type: 1'b0, timeout_ticks: 16'd65535, wake_high_ticks: 20'd1048575,
            start_low_ticks: 20'd1048575, release_high_ticks: 10'd1023,
            settle_ticks: 10'd1023, min_interval_ticks: 22'd4194303};
      load_regs(c);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b1);
      flush_out();

      // random settings and frames; most reads well formed, the first
      // stretch runs with no idling on either side
      base = sent;
      steady = 1'b1;
      while (sent < base + 400) begin
         flush_out();
         c.sensor_type = 1'($urandom_range(1));
         c.timeout_ticks = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 12))
                                                    : 16'($urandom_range(6, 1));
         c.wake_high_ticks = 20'($urandom_range(3));
         c.start_low_ticks = 20'($urandom_range(3, 1));
         c.release_high_ticks = 10'($urandom_range(2));
         c.settle_ticks = 10'($urandom_range(2));
         c.min_interval_ticks = 22'($urandom_range(400));
         load_regs(c);
         repeat ($urandom_range(2, 1)) begin
            repeat ($urandom_range(4)) send_sample(1'b0, 1'($urandom_range(1)));
            roll = $urandom_range(99);
            if (roll < 70)
               f = FLT_NONE;
            else if (roll < 78)
               f = FLT_NO_RESPONSE;
            else if (roll < 88)
               f = (c.timeout_ticks <= 8) ? FLT_LONG_PULSE : FLT_NONE;
            else
               f = FLT_NOISE;
            read_cycle(make_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  $urandom_range(9) != 0), f);
            steady = (sent - base < 200);
         end
      end
      steady = 1'b0;

      flush_out();
      repeat (8) @(posedge clock);   // catch stray rsp items
      if (mirror.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
